FILE: design/byterun_rle_encoder_defines.svh
// ----------------------------------------------------------------------------
// byterun rle encoder assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef BYTERUN_RLE_ENCODER_DEFINES_SVH
`define BYTERUN_RLE_ENCODER_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define BRLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("brle implication check failed");

// next-cycle implication, disabled while reset is asserted
`define BRLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("brle next-cycle check failed");

`endif

FILE: design/brle_pkg.sv
// ----------------------------------------------------------------------------
// brle_pkg
// types and constants shared by the byterun rle encoder modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package brle_pkg;

  // width of run and literal counters
  localparam int unsigned CntW = 8;
  // repeat header base, truncated to a byte after subtraction
  localparam logic [8:0] RepBase = 9'd257;

  // run tracker mode
  typedef enum logic [1:0] {
    MODE_EMPTY = 2'd0,
    MODE_LIT   = 2'd1,
    MODE_REP   = 2'd2
  } mode_e;

  // byte emitter sequencer
  typedef enum logic [1:0] {
    EM_IDLE,
    EM_HDR,
    EM_LIT,
    EM_TAIL
  } emit_state_e;

  // work handed from the run tracker to the emitter for one input transaction
  typedef struct packed {
    logic [CntW-1:0]  lit_n;     // literal bytes to read from the store
    logic [3:0][7:0]  tail;      // bytes after the literal, slot 0 first
    logic [2:0]       tail_len;  // 0..4
    logic             fin;       // last input byte of the block
  } plan_t;

  // literal store write
  typedef struct packed {
    logic            en;
    logic [CntW-1:0] addr;
    logic [7:0]      data;
  } store_wr_t;

endpackage

FILE: design/byterun_rle_encoder.sv
// ----------------------------------------------------------------------------
// byterun_rle_encoder
// streaming byterun1 (packbits style) encoder, one raw byte per transaction
// ----------------------------------------------------------------------------
//   channel  | dir | tdata             | tuser      | tlast
//   s_axis   | in  | data_byte [7:0]   | -          | final_byte
//   m_axis   | out | out_byte0..3      | byte_count | end_of_stream
//
// an input transaction that codes nothing leaves the input side ready; one that
// codes bytes holds it busy while the sequencer emits the literal header, the
// stored bytes and the tail bytes; the literal store yields one byte per cycle.
// the literal store is not cleared at reset; only written entries reach the output.
// a full output register with m_axis_tready low holds the byte sequencer when it has a word to push.
`timescale 1ns / 1ps

module byterun_rle_encoder #(
  parameter int unsigned MaxLiteral = 128,
  parameter int unsigned MaxRepeat  = 129
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // data_byte
  input  logic        s_axis_tlast_i,   // final_byte
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o,   // out_byte0, out_byte1, out_byte2, out_byte3
  output logic [2:0]  m_axis_tuser_o,   // byte_count
  output logic        m_axis_tlast_o    // end_of_stream
);
  import brle_pkg::*;

  mode_e           mode_q, mode_d;
  logic [CntW-1:0] lit_cnt_q, lit_cnt_d;
  logic [CntW-1:0] rep_cnt_q, rep_cnt_d;
  logic [7:0]      prev_q, prev_d;

  logic            accept;
  logic            busy;
  logic [7:0]      b;
  logic            fin;
  logic            pair_en;
  logic [CntW-1:0] pair_cnt;
  logic [7:0]      pair_byte;
  logic [7:0]      pair_hdr;
  logic            lit1_en;
  logic [CntW-1:0] lit_n;
  plan_t           plan;
  store_wr_t       wr;
  logic            start;

  assign b      = s_axis_tdata_i;
  assign fin    = s_axis_tlast_i;
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign s_axis_tready_o = !busy;

  // run tracking for one input byte
  always_comb begin
    mode_d    = mode_q;
    lit_cnt_d = lit_cnt_q;
    rep_cnt_d = rep_cnt_q;
    prev_d    = prev_q;
    pair_en   = 1'b0;
    pair_cnt  = rep_cnt_q;
    pair_byte = prev_q;
    lit1_en   = 1'b0;
    lit_n     = '0;
    wr.en     = 1'b0;
    wr.addr   = '0;
    wr.data   = b;
    if (accept) begin
      case (mode_q)
        MODE_LIT: begin
          if (lit_cnt_q == '0) begin
            wr.en     = 1'b1;
            lit_cnt_d = CntW'(1);
            mode_d    = MODE_LIT;
            prev_d    = b;
          end else if (b == prev_q) begin
            // literal minus its last byte goes out, the pair starts a repeat
            lit_n     = lit_cnt_q - CntW'(1);
            lit_cnt_d = '0;
            prev_d    = b;
            rep_cnt_d = CntW'(2);
            mode_d    = MODE_REP;
            if (CntW'(2) >= CntW'(MaxRepeat)) begin
              pair_en   = 1'b1;
              pair_cnt  = CntW'(2);
              pair_byte = b;
              rep_cnt_d = '0;
              mode_d    = MODE_EMPTY;
            end
          end else begin
            wr.en     = 1'b1;
            wr.addr   = lit_cnt_q;
            lit_cnt_d = lit_cnt_q + CntW'(1);
            prev_d    = b;
            if (lit_cnt_d >= CntW'(MaxLiteral)) begin
              lit_n     = lit_cnt_d;
              lit_cnt_d = '0;
              mode_d    = MODE_EMPTY;
            end
          end
        end
        MODE_REP: begin
          if (b == prev_q) begin
            rep_cnt_d = rep_cnt_q + CntW'(1);
            if (rep_cnt_d >= CntW'(MaxRepeat)) begin
              pair_en   = 1'b1;
              pair_cnt  = rep_cnt_d;
              rep_cnt_d = '0;
              mode_d    = MODE_EMPTY;
            end
          end else begin
            // repeat ends, a new literal starts with this byte
            pair_en   = 1'b1;
            rep_cnt_d = '0;
            wr.en     = 1'b1;
            lit_cnt_d = CntW'(1);
            mode_d    = MODE_LIT;
            prev_d    = b;
          end
        end
        default: begin
          wr.en     = 1'b1;
          lit_cnt_d = CntW'(1);
          mode_d    = MODE_LIT;
          prev_d    = b;
        end
      endcase

      // last byte of the block flushes whatever is pending
      if (fin) begin
        if (mode_d == MODE_LIT) begin
          if (lit_cnt_d == CntW'(1)) begin
            lit1_en = 1'b1;
          end else begin
            lit_n = lit_cnt_d;
          end
        end else if (mode_d == MODE_REP) begin
          pair_en   = 1'b1;
          pair_cnt  = rep_cnt_d;
          pair_byte = prev_d;
        end
        lit_cnt_d = '0;
        rep_cnt_d = '0;
        mode_d    = MODE_EMPTY;
      end
    end
  end

  // plan for the emitter: stored literal, then repeat pair, then single literal
  assign pair_hdr = 8'(RepBase - {1'b0, pair_cnt});

  always_comb begin
    plan.lit_n = lit_n;
    plan.fin   = fin;
    if (pair_en) begin
      plan.tail     = {b, 8'd0, pair_byte, pair_hdr};
      plan.tail_len = lit1_en ? 3'd4 : 3'd2;
    end else begin
      plan.tail     = {8'd0, 8'd0, b, 8'd0};
      plan.tail_len = lit1_en ? 3'd2 : 3'd0;
    end
  end

  assign start = accept && ((lit_n != '0) || (plan.tail_len != 3'd0));

  // run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_EMPTY;
      lit_cnt_q <= '0;
      rep_cnt_q <= '0;
      prev_q    <= 8'd0;
    end else begin
      mode_q    <= mode_d;
      lit_cnt_q <= lit_cnt_d;
      rep_cnt_q <= rep_cnt_d;
      prev_q    <= prev_d;
    end
  end

  brle_emit #(
    .MaxLiteral (MaxLiteral)
  ) u_emit (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start),
    .plan_i          (plan),
    .wr_i            (wr),
    .busy_o          (busy),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

FILE: design/brle_emit.sv
// ----------------------------------------------------------------------------
// brle_emit
// literal store and byte sequencer: header, stored bytes, tail, packed four
// bytes to an output transaction behind one output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module brle_emit #(
  parameter int unsigned MaxLiteral = 128
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  brle_pkg::plan_t     plan_i,
  input  brle_pkg::store_wr_t wr_i,
  output logic                busy_o,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  output logic [31:0]         m_axis_tdata_o,   // out_byte0, out_byte1, out_byte2, out_byte3
  output logic [2:0]          m_axis_tuser_o,   // byte_count
  output logic                m_axis_tlast_o    // end_of_stream
);
  import brle_pkg::*;

  localparam int unsigned AddrW = (MaxLiteral > 2) ? $clog2(MaxLiteral) : 1;

  // literal store
  logic [7:0] mem_q [MaxLiteral];
  logic [7:0] rd_data_q;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;

  emit_state_e state_q, state_d;
  plan_t           plan_q;
  logic [CntW-1:0] idx_q, idx_d;
  logic [CntW-1:0] idx_inc;
  logic [CntW-1:0] lit_last;
  logic [2:0]      tail_last;

  // word being assembled
  logic [2:0][7:0] word_q, word_d;
  logic [1:0]      wcnt_q, wcnt_d;

  // output register
  logic [3:0][7:0] ob_q, ob_d;
  logic [2:0]      ocnt_q, ocnt_d;
  logic            oeos_q, oeos_d;
  logic            ovalid_q, ovalid_d;

  logic [7:0] cur_byte;
  logic       is_last;
  logic       push;
  logic       out_free;
  logic       adv;

  assign idx_inc   = idx_q + CntW'(1);
  assign lit_last  = plan_q.lit_n - CntW'(1);
  assign tail_last = plan_q.tail_len - 3'd1;
  assign out_free  = !ovalid_q || m_axis_tready_i;

  // store write and registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr[AddrW-1:0]] <= wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  // sequencer outputs
  always_comb begin
    cur_byte = 8'd0;
    is_last  = 1'b0;
    rd_addr  = '0;
    unique case (state_q)
      EM_HDR: begin
        cur_byte = lit_last;
      end
      EM_LIT: begin
        cur_byte = rd_data_q;
        is_last  = (idx_q == lit_last) && (plan_q.tail_len == 3'd0);
        rd_addr  = idx_inc[AddrW-1:0];
      end
      EM_TAIL: begin
        cur_byte = plan_q.tail[idx_q[1:0]];
        is_last  = ({1'b0, idx_q[1:0]} == tail_last);
      end
      default: begin
        cur_byte = 8'd0;
      end
    endcase
    push  = (wcnt_q == 2'd3) || is_last;
    adv   = (state_q != EM_IDLE) && (!push || out_free);
    rd_en = adv && ((state_q == EM_HDR) || (state_q == EM_LIT));
  end

  // sequencer next state
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    unique case (state_q)
      EM_IDLE: begin
        if (start_i) begin
          idx_d   = '0;
          state_d = (plan_i.lit_n != '0) ? EM_HDR : EM_TAIL;
        end
      end
      EM_HDR: begin
        if (adv) begin
          state_d = EM_LIT;
          idx_d   = '0;
        end
      end
      EM_LIT: begin
        if (adv) begin
          if (idx_q == lit_last) begin
            idx_d   = '0;
            state_d = (plan_q.tail_len != 3'd0) ? EM_TAIL : EM_IDLE;
          end else begin
            idx_d = idx_inc;
          end
        end
      end
      EM_TAIL: begin
        if (adv) begin
          idx_d   = idx_inc;
          state_d = is_last ? EM_IDLE : EM_TAIL;
        end
      end
      default: begin
        state_d = EM_IDLE;
      end
    endcase
  end

  // packing into words and the output register
  always_comb begin
    word_d   = word_q;
    wcnt_d   = wcnt_q;
    ob_d     = ob_q;
    ocnt_d   = ocnt_q;
    oeos_d   = oeos_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    if (state_q == EM_IDLE && start_i) begin
      wcnt_d = 2'd0;
    end
    if (adv) begin
      if (push) begin
        for (int j = 0; j < 3; j++) begin
          if (2'(j) < wcnt_q) begin
            ob_d[j] = word_q[j];
          end else if (2'(j) == wcnt_q) begin
            ob_d[j] = cur_byte;
          end else begin
            ob_d[j] = 8'd0;
          end
        end
        ob_d[3]  = (wcnt_q == 2'd3) ? cur_byte : 8'd0;
        ocnt_d   = {1'b0, wcnt_q} + 3'd1;
        oeos_d   = plan_q.fin && is_last;
        ovalid_d = 1'b1;
        wcnt_d   = 2'd0;
      end else begin
        for (int j = 0; j < 3; j++) begin
          if (2'(j) == wcnt_q) begin
            word_d[j] = cur_byte;
          end
        end
        wcnt_d = wcnt_q + 2'd1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= EM_IDLE;
      idx_q    <= '0;
      wcnt_q   <= 2'd0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      idx_q    <= idx_d;
      wcnt_q   <= wcnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == EM_IDLE && start_i) begin
      plan_q <= plan_i;
    end
    word_q <= word_d;
    ob_q   <= ob_d;
    ocnt_q <= ocnt_d;
    oeos_q <= oeos_d;
  end

  assign busy_o          = (state_q != EM_IDLE);
  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = ob_q;
  assign m_axis_tuser_o  = ocnt_q;
  assign m_axis_tlast_o  = oeos_q;

endmodule

FILE: design/brle_checker.sv
// ----------------------------------------------------------------------------
// brle_checker
// port-level checks for the byterun rle encoder, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "byterun_rle_encoder_defines.svh"

module brle_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        s_axis_tlast_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o,
  input logic [2:0]  m_axis_tuser_o,
  input logic        m_axis_tlast_o
);

  logic        out_stall;
  logic [35:0] out_word;
  logic        count_ok;
  logic        single_byte;
  logic        in_final;

  // helper terms for the properties
  assign out_stall   = m_axis_tvalid_o && !m_axis_tready_i;
  assign out_word    = {m_axis_tlast_o, m_axis_tuser_o, m_axis_tdata_o};
  assign count_ok    = (m_axis_tuser_o != 3'd0) && (m_axis_tuser_o <= 3'd4);
  assign single_byte = m_axis_tvalid_o && (m_axis_tuser_o == 3'd1);
  assign in_final    = s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i;

  // a stalled output transaction keeps its payload
  `BRLE_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_stall, m_axis_tvalid_o && $stable(out_word))

  // every result carries one to four bytes
  `BRLE_ASSERT_IMP(a_count_range, clk_i, rst_ni, m_axis_tvalid_o, count_ok)

  // a single-byte result has its unused bytes cleared
  `BRLE_ASSERT_IMP(a_pad_zero, clk_i, rst_ni, single_byte, m_axis_tdata_o[31:8] == 24'd0)

  // the final byte always codes something, so the input side stalls next
  `BRLE_ASSERT_NXT(a_final_busy, clk_i, rst_ni, in_final, !s_axis_tready_o)

endmodule

bind byterun_rle_encoder brle_checker u_brle_checker (.*);

FILE: tb/byterun_rle_encoder_tb.sv
// ----------------------------------------------------------------------------
// byterun_rle_encoder_tb
// self-checking bench: a scoreboard class keeps its own copy of the run
// tracker state, codes every accepted input byte and checks each output word
// against the oldest expected word; both stream sides stall at random
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module byterun_rle_encoder_tb;
  import brle_pkg::*;

  localparam int unsigned MaxLiteral = 128;
  localparam int unsigned MaxRepeat  = 129;
  localparam int unsigned CycleLimit = 400000;
  // longest flush is a full literal, one store byte per cycle while the output register is free
  localparam int unsigned TailCycles = 400;

  // one output word as the block should present it
  typedef struct packed {
    logic [3:0][7:0] bytes;  // out_byte0 in slot 0
    logic [2:0]      cnt;
    logic            eos;
  } coded_word_t;

  // run tracker copy plus the queue of expected output words
  class packbits_scoreboard;
    logic [7:0]  lit_store [MaxLiteral];
    logic [7:0]  lit_cnt;
    logic [7:0]  rep_cnt;
    logic [7:0]  run_byte;
    mode_e       mode;
    logic [7:0]  coded [$];
    coded_word_t pending_words [$];
    int          errors;

    function new();
      lit_cnt  = '0;
      rep_cnt  = '0;
      run_byte = '0;
      mode     = MODE_EMPTY;
      errors   = 0;
    endfunction

    // literal header then the held bytes, oldest first
    function void put_literal(int unsigned n);
      if (n == 0) return;
      coded.push_back(8'(n - 1));
      for (int i = 0; i < n; i++) coded.push_back(lit_store[7'(i)]);
    endfunction

    // repeat header then the run byte
    function void put_repeat();
      logic [8:0] hdr;
      hdr = RepBase - {1'b0, rep_cnt};
      coded.push_back(hdr[7:0]);
      coded.push_back(run_byte);
    endfunction

    function void open_literal(logic [7:0] b);
      lit_store[0] = b;
      lit_cnt      = 8'd1;
      mode         = MODE_LIT;
    endfunction

    // code one accepted input transaction and queue the words it yields
    function void note_input(logic [7:0] b, logic fin);
      coded_word_t w;
      int unsigned nwords;
      coded.delete();
      if (mode == MODE_LIT && lit_cnt >= 1) begin
        if (b == lit_store[7'(lit_cnt - 8'd1)]) begin
          // literal minus its last byte goes out, the pair becomes a repeat
          put_literal(lit_cnt - 1);
          lit_cnt  = '0;
          run_byte = b;
          rep_cnt  = 8'd2;
          mode     = MODE_REP;
          if (rep_cnt >= MaxRepeat) begin
            put_repeat();
            rep_cnt = '0;
            mode    = MODE_EMPTY;
          end
        end else begin
          lit_store[7'(lit_cnt)] = b;
          lit_cnt = lit_cnt + 8'd1;
          if (lit_cnt >= MaxLiteral) begin
            put_literal(lit_cnt);
            lit_cnt = '0;
            mode    = MODE_EMPTY;
          end
        end
      end else if (mode == MODE_REP) begin
        if (b == run_byte) begin
          rep_cnt = rep_cnt + 8'd1;
          if (rep_cnt >= MaxRepeat) begin
            put_repeat();
            rep_cnt = '0;
            mode    = MODE_EMPTY;
          end
        end else begin
          put_repeat();
          rep_cnt = '0;
          open_literal(b);
        end
      end else begin
        open_literal(b);
      end

      // last byte of the block flushes whatever is pending
      if (fin) begin
        if (mode == MODE_LIT) put_literal(lit_cnt);
        else if (mode == MODE_REP) put_repeat();
        lit_cnt = '0;
        rep_cnt = '0;
        mode    = MODE_EMPTY;
      end

      // pack four to a word
      nwords = (coded.size() + 3) / 4;
      for (int k = 0; k < nwords; k++) begin
        w = '0;
        for (int j = 0; j < 4; j++) begin
          if (4 * k + j < coded.size()) begin
            w.bytes[j] = coded[4 * k + j];
            w.cnt      = w.cnt + 3'd1;
          end
        end
        w.eos = fin && (k == nwords - 1);
        pending_words.push_back(w);
      end
    endfunction

    // compare one accepted output transaction with the oldest expectation
    function void match_word(logic [31:0] tdata, logic [2:0] tuser, logic tlast);
      coded_word_t w;
      if (pending_words.size() == 0) begin
        $error("output word with nothing expected: tdata %08h tuser %0d tlast %0b",
               tdata, tuser, tlast);
        errors++;
        return;
      end
      w = pending_words.pop_front();
      for (int j = 0; j < 4; j++) begin
        if (w.bytes[j] !== tdata[8 * j +: 8]) begin
          $error("out_byte%0d mismatch: expected %02h, actual %02h",
                 j, w.bytes[j], tdata[8 * j +: 8]);
          errors++;
        end
      end
      if (w.cnt !== tuser) begin
        $error("byte_count mismatch: expected %0d, actual %0d", w.cnt, tuser);
        errors++;
      end
      if (w.eos !== tlast) begin
        $error("end_of_stream mismatch: expected %0b, actual %0b", w.eos, tlast);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [2:0]  m_axis_tuser_o;
  logic        m_axis_tlast_o;

  int unsigned src_idle_pct  = 15;
  int unsigned sink_idle_pct = 85;
  int unsigned sent_items    = 0;
  int unsigned cycles        = 0;

  packbits_scoreboard sb;

  byterun_rle_encoder #(
    .MaxLiteral(MaxLiteral),
    .MaxRepeat (MaxRepeat)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tlast_i (s_axis_tlast),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  // clock, 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // output side: check accepted words, stall at random
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready)
      sb.match_word(m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
    m_axis_tready <= ($urandom_range(0, 99) >= sink_idle_pct);
  end

  function automatic logic [7:0] pick_byte(bit narrow);
    return narrow ? 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 255));
  endfunction

  // one input transaction, with random idle cycles ahead of it
  task automatic send_byte(input logic [7:0] d, input logic fin);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tlast  <= fin;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_input(d, fin);
    sent_items++;
  endtask

  task automatic send_repeat(input int unsigned n, input logic [7:0] v, input bit fin_end);
    for (int i = 0; i < n; i++) send_byte(v, fin_end && (i == n - 1));
  endtask

  // run of bytes with no two neighbors equal
  task automatic send_literal(input int unsigned n, input bit narrow, input bit fin_end,
                              output logic [7:0] last);
    logic [7:0] v;
    logic [7:0] p;
    p = pick_byte(narrow);
    for (int i = 0; i < n; i++) begin
      if (i == 0) begin
        v = p;
      end else begin
        do v = pick_byte(narrow); while (v == p);
      end
      send_byte(v, fin_end && (i == n - 1));
      p = v;
    end
    last = p;
  endtask

  // random mix of literals, repeats and loose bytes up to an item count
  task automatic send_mix(input int unsigned upto);
    int unsigned r;
    int unsigned len;
    bit          narrow;
    bit          fin_end;
    logic [7:0]  last;
    while (sent_items < upto) begin
      r       = $urandom_range(0, 99);
      narrow  = 1'($urandom_range(0, 1));
      len     = ($urandom_range(0, 39) == 0) ? $urandom_range(120, 135)
                                             : $urandom_range(1, 10);
      fin_end = ($urandom_range(0, 3) == 0);
      if (r < 15) send_byte(pick_byte(1'b0), $urandom_range(0, 7) == 0);
      else if (r < 55) send_literal(len, narrow, fin_end, last);
      else send_repeat(len, pick_byte(narrow), fin_end);
    end
  endtask

  // hold the sender until every expected word has come out
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] last;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: lone bytes, shortest repeat, literal then pair, repeat then
    // literal, literal cut short by a pair, bit patterns
    send_byte(8'h00, 1'b1);
    send_byte(8'hff, 1'b1);
    send_byte(8'h5a, 1'b0);
    send_byte(8'h5a, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h03, 1'b1);
    send_byte(8'h07, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h07, 1'b0);
    send_byte(8'h08, 1'b1);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'ha5, 1'b1);
    send_byte(8'h80, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h7f, 1'b1);
    send_byte(8'h55, 1'b0);
    send_byte(8'haa, 1'b1);

    // phase 1: full-length literal, then a pair across its limit
    send_literal($urandom_range(127, 129), 1'($urandom_range(0, 1)), 1'b0, last);
    send_repeat(3, last, 1'b0);
    send_mix(sent_items + 10);
    drain_results();

    // phase 2: sender mostly idle, full-length repeat first
    src_idle_pct  = 85;
    sink_idle_pct = 15;
    send_repeat($urandom_range(128, 131), pick_byte(1'b0), 1'b0);
    send_mix(sent_items + 10);
    drain_results();

    // phase 3: no idling on either side
    src_idle_pct  = 0;
    sink_idle_pct = 0;
    send_mix(sent_items + 85);
    send_byte(pick_byte(1'b0), 1'b1);
    drain_results();

    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending_words.size() != 0) begin
      $error("%0d expected words never arrived", sb.pending_words.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/brle_pkg.sv
design/brle_emit.sv
design/byterun_rle_encoder.sv
design/brle_checker.sv
tb/byterun_rle_encoder_tb.sv
